// ===== rtl/eic_pkg.sv =====
// ----------------------------------------------------------------------------
// eic_pkg
// Shared types and constants of the external interrupt controller: word
// layouts, operation codes, register offsets and the sense decoder.
// ----------------------------------------------------------------------------
package eic_pkg;

  // number of external lines handled by the controller
  localparam int LINE_COUNT = 16;
  // lines that own a sense code (two 32-bit config registers, 4 bits each)
  localparam int SENSE_LINES = 16;

  // bus operation codes
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2
  } op_t;

  // register byte offsets
  localparam logic [4:0] OFS_STATUS   = 5'h01;
  localparam logic [4:0] OFS_INTENCLR = 5'h08;
  localparam logic [4:0] OFS_INTENSET = 5'h0C;
  localparam logic [4:0] OFS_INTFLAG  = 5'h10;
  localparam logic [4:0] OFS_WAKEUP   = 5'h14;
  localparam logic [4:0] OFS_CONFIG0  = 5'h18;
  localparam logic [4:0] OFS_CONFIG1  = 5'h1C;

  // configuration port register indexes
  typedef enum logic [1:0] {
    CFG_SENSE_LOW  = 2'd0,
    CFG_SENSE_HIGH = 2'd1,
    CFG_WAKE_MASK  = 2'd2,
    CFG_CTRL_ON    = 2'd3
  } cfg_idx_t;

  // sense codes (low 3 bits of each 4-bit field)
  typedef enum logic [2:0] {
    SENSE_NONE = 3'd0,
    SENSE_RISE = 3'd1,
    SENSE_FALL = 3'd2,
    SENSE_BOTH = 3'd3,
    SENSE_HIGH = 3'd4,
    SENSE_LOW  = 3'd5
  } sense_t;

  // input word
  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  reg_offset;
    logic [31:0] write_value;
    logic [15:0] pin_levels;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [31:0] read_value;
    logic        irq_request;
    logic        wake_request;
  } out_word_t;

  // detection of one line from its sense code and its old and new level
  function automatic logic sense_hit(input logic [2:0] code, input logic cur,
                                     input logic old);
    logic hit;
    case (code)
      SENSE_RISE: hit = cur & ~old;
      SENSE_FALL: hit = ~cur & old;
      SENSE_BOTH: hit = cur ^ old;
      SENSE_HIGH: hit = cur;
      SENSE_LOW:  hit = ~cur;
      default:    hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== rtl/external_interrupt_controller.sv =====
// ----------------------------------------------------------------------------
// external_interrupt_controller
// Sixteen-line external interrupt controller: edge/level detection of the
// pins, enable and flag registers on a small bus, interrupt and wake requests.
// ----------------------------------------------------------------------------
//
//  channel | ports                     | direction | handshake
//  --------+---------------------------+-----------+-----------------------
//  input   | in_valid/in_ready/in_word | in        | valid and ready
//  result  | out_valid/out_ready/out_word | out    | valid and ready
//  config  | cfg_we/cfg_index/cfg_wdata| in        | write enable, no wait
//
// One word is taken per cycle while in_ready is high; each result is registered.
// The whole step (read mux, detection, flag update) is one level of logic
// between the accepted word and the result register.
// A two-entry output (result register plus skid register) keeps in_ready
// high while one result waits; in_ready drops only when both are full.
// Reset (synchronous, active low) clears config, state and valid registers.
module external_interrupt_controller
  import eic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // configuration registers
  logic [31:0]           sense_low_r;
  logic [31:0]           sense_high_r;
  logic [15:0]           wake_mask_r;
  logic                  ctrl_on_r;

  // controller state
  logic [LINE_COUNT-1:0] prev_levels_r, prev_levels_nxt;
  logic [LINE_COUNT-1:0] flags_r, flags_nxt;
  logic [LINE_COUNT-1:0] enables_r, enables_nxt;

  // output stage
  logic                  out_valid_r, out_valid_nxt;
  logic                  skid_valid_r, skid_valid_nxt;
  out_word_t             out_word_r, out_word_nxt;
  out_word_t             skid_word_r, skid_word_nxt;

  logic                  in_accept;
  logic                  out_free;
  logic [LINE_COUNT-1:0] pins;
  logic [LINE_COUNT-1:0] wdata;
  logic [LINE_COUNT-1:0] hits;
  logic [31:0]           rd_value;
  out_word_t             result;

  assign in_ready  = ~skid_valid_r;
  assign in_accept = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign pins  = LINE_COUNT'(in_word.pin_levels);
  assign wdata = LINE_COUNT'(in_word.write_value);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sense_low_r  <= '0;
      sense_high_r <= '0;
      wake_mask_r  <= '0;
      ctrl_on_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SENSE_LOW:  sense_low_r  <= cfg_wdata;
        CFG_SENSE_HIGH: sense_high_r <= cfg_wdata;
        CFG_WAKE_MASK:  wake_mask_r  <= cfg_wdata[15:0];
        CFG_CTRL_ON:    ctrl_on_r    <= cfg_wdata[0];
        default:        ctrl_on_r    <= ctrl_on_r;
      endcase
    end
  end

  // read mux, shows the state before the step
  always_comb begin
    rd_value = '0;
    if (in_word.operation == OP_READ) begin
      case (in_word.reg_offset)
        OFS_INTENCLR, OFS_INTENSET: rd_value = 32'(enables_r);
        OFS_INTFLAG:                rd_value = 32'(flags_r);
        OFS_WAKEUP:                 rd_value = 32'(wake_mask_r);
        OFS_CONFIG0:                rd_value = sense_low_r;
        OFS_CONFIG1:                rd_value = sense_high_r;
        OFS_STATUS:                 rd_value = '0;
        default:                    rd_value = '0;
      endcase
    end
  end

  // per-line detection
  always_comb begin
    hits = '0;
    for (int n = 0; n < LINE_COUNT; n++) begin
      if (ctrl_on_r && n < 8) begin
        hits[n] = sense_hit(sense_low_r[4*n +: 3], pins[n], prev_levels_r[n]);
      end else if (ctrl_on_r && n < SENSE_LINES) begin
        hits[n] = sense_hit(sense_high_r[4*(n-8) +: 3], pins[n], prev_levels_r[n]);
      end
    end
  end

  // bus write and flag update; a detection wins over a flag clear
  always_comb begin
    enables_nxt     = enables_r;
    flags_nxt       = flags_r;
    prev_levels_nxt = pins;
    if (in_word.operation == OP_WRITE) begin
      case (in_word.reg_offset)
        OFS_INTENSET: enables_nxt = enables_r | wdata;
        OFS_INTENCLR: enables_nxt = enables_r & ~wdata;
        OFS_INTFLAG:  flags_nxt   = flags_r & ~wdata;
        default:      enables_nxt = enables_r;
      endcase
    end
    flags_nxt = flags_nxt | hits;

    result.read_value   = rd_value;
    result.irq_request  = |(flags_nxt & enables_nxt);
    result.wake_request = |(flags_nxt & wake_mask_r);
  end

  // controller state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_levels_r <= '0;
      flags_r       <= '0;
      enables_r     <= '0;
    end else if (in_accept) begin
      prev_levels_r <= prev_levels_nxt;
      flags_r       <= flags_nxt;
      enables_r     <= enables_nxt;
    end
  end

  // result register and skid register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_word_nxt   = out_word_r;
    skid_word_nxt  = skid_word_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (skid_valid_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_word_nxt   = skid_word_r;
      skid_valid_nxt = 1'b0;
    end else if (in_accept && out_free) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = result;
    end else if (in_accept) begin
      skid_valid_nxt = 1'b1;
      skid_word_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

`ifndef NO_ASSERTIONS
  // skid entry only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register valid while result register empty");

  // flags and enables only move when a word is accepted
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> ($stable(flags_r) && $stable(enables_r)))
    else $error("controller state changed without an accepted word");

  // no new flag while the controller is off
  a_no_detect_off: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !ctrl_on_r) |=> ((flags_r & ~$past(flags_r)) == '0))
    else $error("flag set while controller disabled");
`endif

endmodule
